/* rtl/ppo_pkg.sv */
package ppo_pkg;

	// Fixed pixel layout
	localparam int unsigned NUM_LANES  = 3;
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned NUM_W      = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	typedef enum logic [1:0] {
		MODE_COPY     = 2'd0,
		MODE_NEGATIVE = 2'd1,
		MODE_BRIGHT   = 2'd2,
		MODE_CONTRAST = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 3'd0,
		CFG_BRIGHT = 3'd1,
		CFG_LOW    = 3'd2,
		CFG_HIGH   = 3'd3
	} cfg_reg_t;

	// Lane after the prepare stage
	typedef struct packed {
		logic [PIX_W-1:0] direct;
		logic             use_div;
		logic [PIX_W-1:0] absdiff;
	} prep_lane_t;

	// Lane inside the divider stages
	typedef struct packed {
		logic [PIX_W-1:0] direct;
		logic             use_div;
		logic             sat;
		logic [NUM_W-1:0] rem;
		logic [PIX_W-1:0] quo;
	} div_lane_t;

	// Two restoring steps, quotient bits hi_bit and hi_bit-1
	function automatic div_lane_t div_two_steps(input div_lane_t lane,
		input logic [PIX_W-1:0] den, input int unsigned hi_bit);
		div_lane_t        r;
		logic [NUM_W-1:0] trial;
		int unsigned      b;
		r = lane;
		for (int k = 0; k < 2; k++) begin
			b     = hi_bit - k;
			trial = NUM_W'(den) << b;
			if (r.rem >= trial) begin
				r.rem    = r.rem - trial;
				r.quo[b] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

/* rtl/pixel_point_operation_core.sv */
// Pipeline from input transfer to output valid: prepare, scale and four divide stages.
// Throughput: one pixel per cycle; the whole pipe advances when the output is free or taken.
// Contrast division is a restoring divider, two quotient bits per stage over stages 3..6.
// Reset (arst_n low, async): mode copy, offset 0, low 0, high 255, pipeline emptied.
// Configuration is taken every cycle; writes are expected only while the pipe is empty.
module pixel_point_operation_core #(
	parameter int unsigned CHANNELS = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppo_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ppo_pkg::PIX_W-1:0]         chan0_in,
	input  logic [ppo_pkg::PIX_W-1:0]         chan1_in,
	input  logic [ppo_pkg::PIX_W-1:0]         chan2_in,
	// pixel output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ppo_pkg::PIX_W-1:0]         chan0_out,
	output logic [ppo_pkg::PIX_W-1:0]         chan1_out,
	output logic [ppo_pkg::PIX_W-1:0]         chan2_out
);

	localparam int unsigned LANES = ppo_pkg::NUM_LANES;
	localparam int unsigned PW    = ppo_pkg::PIX_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	ppo_pkg::mode_t   mode_q;
	logic signed [8:0] offset_q;
	logic [PW-1:0]    low_q;
	logic [PW-1:0]    high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ppo_pkg::MODE_COPY;
			offset_q <= '0;
			low_q    <= '0;
			high_q   <= ppo_pkg::PIX_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppo_pkg::CFG_MODE:   mode_q   <= ppo_pkg::mode_t'(cfg_data[1:0]);
				ppo_pkg::CFG_BRIGHT: offset_q <= $signed(cfg_data[8:0]);
				ppo_pkg::CFG_LOW:    low_q    <= cfg_data[PW-1:0];
				ppo_pkg::CFG_HIGH:   high_q   <= cfg_data[PW-1:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage moves together. A bubble in the last
	// stage or a taken output lets the whole pipe advance.
	// ------------------------------------------------------------------
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign adv      = !v_s6 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: per-lane prepare. Non-contrast modes, the equal-levels
	// case and a negative ratio resolve here; only the positive contrast
	// case goes on through the divider.
	// ------------------------------------------------------------------
	logic [PW-1:0]       pix_in [LANES];
	ppo_pkg::prep_lane_t prep   [LANES];
	logic signed [8:0]   den_sd;
	logic [PW-1:0]       den_abs;

	assign pix_in[0] = chan0_in;
	assign pix_in[1] = chan1_in;
	assign pix_in[2] = chan2_in;

	assign den_sd  = $signed({1'b0, high_q}) - $signed({1'b0, low_q});
	assign den_abs = den_sd[8] ? PW'(-den_sd) : den_sd[PW-1:0];

	always_comb begin
		logic signed [8:0] diff;
		logic signed [9:0] bsum;
		for (int c = 0; c < LANES; c++) begin
			diff = $signed({1'b0, pix_in[c]}) - $signed({1'b0, low_q});
			bsum = $signed({2'b00, pix_in[c]}) + $signed({offset_q[8], offset_q});
			prep[c].absdiff = diff[8] ? PW'(-diff) : diff[PW-1:0];
			prep[c].use_div = 1'b0;
			prep[c].direct  = pix_in[c];
			if (c < CHANNELS) begin
				case (mode_q)
					ppo_pkg::MODE_COPY:     prep[c].direct = pix_in[c];
					ppo_pkg::MODE_NEGATIVE: prep[c].direct = ppo_pkg::PIX_MAX - pix_in[c];
					ppo_pkg::MODE_BRIGHT: begin
						if (bsum[9])
							prep[c].direct = '0;
						else if (bsum > 10'sd255)
							prep[c].direct = ppo_pkg::PIX_MAX;
						else
							prep[c].direct = bsum[PW-1:0];
					end
					ppo_pkg::MODE_CONTRAST: begin
						if (high_q == low_q) begin
							// flat ramp: a hard threshold at low
							prep[c].direct = (pix_in[c] >= low_q) ? ppo_pkg::PIX_MAX : '0;
						end else begin
							// signs differ -> quotient <= 0 -> clamps to zero
							prep[c].direct  = '0;
							prep[c].use_div = !(diff[8] ^ den_sd[8]);
						end
					end
					default: prep[c].direct = pix_in[c];
				endcase
			end
		end
	end

	ppo_pkg::prep_lane_t lane_s1 [LANES];
	logic [PW-1:0]       den_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1 <= prep;
			den_s1  <= den_abs;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: numerator 255*|v-low| and the saturation test. Once
	// num < den*256 the quotient fits eight bits.
	// ------------------------------------------------------------------
	ppo_pkg::div_lane_t scale [LANES];

	always_comb begin
		logic [ppo_pkg::NUM_W-1:0] num;
		for (int c = 0; c < LANES; c++) begin
			num = {lane_s1[c].absdiff, 8'd0} - ppo_pkg::NUM_W'(lane_s1[c].absdiff);
			scale[c].direct  = lane_s1[c].direct;
			scale[c].use_div = lane_s1[c].use_div;
			scale[c].sat     = num >= {den_s1, 8'd0};
			scale[c].rem     = num;
			scale[c].quo     = '0;
		end
	end

	ppo_pkg::div_lane_t lane_s2 [LANES];
	ppo_pkg::div_lane_t lane_s3 [LANES];
	ppo_pkg::div_lane_t lane_s4 [LANES];
	ppo_pkg::div_lane_t lane_s5 [LANES];
	ppo_pkg::div_lane_t lane_s6 [LANES];
	logic [PW-1:0]      den_s2, den_s3, den_s4, den_s5;

	// ------------------------------------------------------------------
	// Stages 3..6: two quotient bits each, MSB first.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s2 <= scale;
			den_s2  <= den_s1;
			den_s3  <= den_s2;
			den_s4  <= den_s3;
			den_s5  <= den_s4;
			for (int c = 0; c < LANES; c++) begin
				lane_s3[c] <= ppo_pkg::div_two_steps(lane_s2[c], den_s2, 7);
				lane_s4[c] <= ppo_pkg::div_two_steps(lane_s3[c], den_s3, 5);
				lane_s5[c] <= ppo_pkg::div_two_steps(lane_s4[c], den_s4, 3);
				lane_s6[c] <= ppo_pkg::div_two_steps(lane_s5[c], den_s5, 1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Output select from the last register stage
	// ------------------------------------------------------------------
	logic [PW-1:0] pix_out [LANES];

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			if (!lane_s6[c].use_div)
				pix_out[c] = lane_s6[c].direct;
			else if (lane_s6[c].sat)
				pix_out[c] = ppo_pkg::PIX_MAX;
			else
				pix_out[c] = lane_s6[c].quo;
		end
	end

	assign out_valid = v_s6;
	assign chan0_out = pix_out[0];
	assign chan1_out = pix_out[1];
	assign chan2_out = pix_out[2];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted pixel did not enter stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !out_ready |=> v_s6 && $stable(lane_s6[0].quo) && $stable(lane_s5[0].rem))
		else $error("pipe moved during output stall");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && lane_s2[0].use_div |-> den_s2 != '0)
		else $error("divide issued with zero divisor");

	a_rem_bound_in: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && lane_s2[1].use_div && !lane_s2[1].sat |-> lane_s2[1].rem < {den_s2, 8'd0})
		else $error("unsaturated numerator exceeds quotient range");

	a_rem_bound_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && lane_s6[2].use_div && !lane_s6[2].sat |-> lane_s6[2].rem < ppo_pkg::NUM_W'(den_s5))
		else $error("divider remainder not below divisor");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

	// Lanes that get the point operation; the rest pass through untouched.
	localparam int unsigned MAPPED_LANES = 3;
	// Pipe is six stages deep; give it a little margin after the last result.
	localparam int unsigned DRAIN_CYCLES = 12;
	// Long receiver hold-off, well past the pipe depth, so in_ready must drop.
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned HOLD_AFTER   = 250;
	localparam int unsigned RAND_PHASES  = 14;
	localparam int unsigned PHASE_PIXELS = 100;
	localparam int unsigned N_PIX        = RAND_PHASES * PHASE_PIXELS;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int unsigned MAX_GAP      = 7;
	localparam int unsigned LIMIT_NS     = 2_000_000;
	localparam int          LEVEL_MAX    = 255;
	// register index past the end of the list, must be dropped
	localparam logic [ppo_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

	typedef logic [ppo_pkg::NUM_LANES-1:0][ppo_pkg::PIX_W-1:0] pixel_t;

	typedef struct {
		logic                            is_cfg;
		logic [ppo_pkg::CFG_IDX_W-1:0]  idx;
		logic [ppo_pkg::CFG_DATA_W-1:0] data;
		pixel_t                          pix;
	} entry_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ppo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ppo_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [ppo_pkg::PIX_W-1:0] chan0_in = '0;
	logic [ppo_pkg::PIX_W-1:0] chan1_in = '0;
	logic [ppo_pkg::PIX_W-1:0] chan2_in = '0;

	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [ppo_pkg::PIX_W-1:0] chan0_out;
	logic [ppo_pkg::PIX_W-1:0] chan1_out;
	logic [ppo_pkg::PIX_W-1:0] chan2_out;

	entry_t item_q[$];
	pixel_t exp_q[$];

	int unsigned tx_wait   = 0;
	int unsigned rx_wait   = 0;
	int unsigned rcv_cnt   = 0;
	int unsigned err_cnt   = 0;
	int unsigned hold_cnt  = 0;
	logic        hold_on   = 1'b0;
	logic        hold_done = 1'b0;

	// mirror of the block's configuration registers
	ppo_pkg::mode_t cfg_mode   = ppo_pkg::MODE_COPY;
	int             cfg_offset = 0;
	int             cfg_low    = 0;
	int             cfg_high   = LEVEL_MAX;

	pixel_point_operation_core #(
		.CHANNELS (MAPPED_LANES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.chan0_in  (chan0_in),
		.chan1_in  (chan1_in),
		.chan2_in  (chan2_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.chan0_out (chan0_out),
		.chan1_out (chan1_out),
		.chan2_out (chan2_out)
	);

	function automatic int clamp_level(input int x);
		if (x < 0)
			return 0;
		if (x > LEVEL_MAX)
			return LEVEL_MAX;
		return x;
	endfunction

	function automatic logic [ppo_pkg::PIX_W-1:0] ref_level(input logic [ppo_pkg::PIX_W-1:0] v);
		int iv;
		int r;
		iv = int'(v);
		case (cfg_mode)
			ppo_pkg::MODE_NEGATIVE: r = LEVEL_MAX - iv;
			ppo_pkg::MODE_BRIGHT:   r = clamp_level(iv + cfg_offset);
			ppo_pkg::MODE_CONTRAST: begin
				if (cfg_high == cfg_low)
					r = (iv >= cfg_low) ? LEVEL_MAX : 0;
				else
					r = clamp_level((LEVEL_MAX * (iv - cfg_low)) / (cfg_high - cfg_low));
			end
			default: r = iv;
		endcase
		return r[ppo_pkg::PIX_W-1:0];
	endfunction

	function automatic pixel_t predict(input pixel_t px);
		pixel_t r;
		for (int c = 0; c < ppo_pkg::NUM_LANES; c++)
			r[c] = (c < MAPPED_LANES) ? ref_level(px[c]) : px[c];
		return r;
	endfunction

	function automatic void apply_cfg(input logic [ppo_pkg::CFG_IDX_W-1:0] idx,
		input logic [ppo_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			ppo_pkg::CFG_MODE:   cfg_mode = ppo_pkg::mode_t'(data[1:0]);
			ppo_pkg::CFG_BRIGHT: cfg_offset = data[ppo_pkg::CFG_DATA_W-1] ?
				int'(data) - (1 << ppo_pkg::CFG_DATA_W) : int'(data);
			ppo_pkg::CFG_LOW:    cfg_low  = int'(data[ppo_pkg::PIX_W-1:0]);
			ppo_pkg::CFG_HIGH:   cfg_high = int'(data[ppo_pkg::PIX_W-1:0]);
			default: ;
		endcase
	endfunction

	task automatic push_cfg(input logic [ppo_pkg::CFG_IDX_W-1:0] idx,
		input logic [ppo_pkg::CFG_DATA_W-1:0] data);
		entry_t e;
		e.is_cfg = 1'b1;
		e.idx    = idx;
		e.data   = data;
		e.pix    = '0;
		item_q.push_back(e);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// stimulus: per phase a block of register writes, then a run of pixels
	initial begin : fill_blk
		entry_t                         e;
		int unsigned                    rnd;
		logic [ppo_pkg::PIX_W-1:0]      lo;
		logic [ppo_pkg::PIX_W-1:0]      hi;
		logic [ppo_pkg::CFG_DATA_W-1:0] offs;
		for (int p = 0; p < RAND_PHASES; p++) begin
			rnd  = $urandom;
			lo   = rnd[7:0];
			hi   = rnd[15:8];
			offs = rnd[24:16];
			if (p == 3)
				hi = lo;          // flat ramp, hard threshold
			if (p == 7) begin
				lo = 8'd200;      // high below low, inverted ramp
				hi = 8'd40;
			end
			if (p == 6)
				offs = 9'h100;    // most negative offset
			if (p == 10)
				offs = 9'd255;
			rnd = $urandom;
			push_cfg(CFG_SPARE, rnd[8:0]);
			push_cfg(ppo_pkg::CFG_BRIGHT, offs);
			push_cfg(ppo_pkg::CFG_LOW, {rnd[9], lo});
			push_cfg(ppo_pkg::CFG_HIGH, {rnd[10], hi});
			push_cfg(ppo_pkg::CFG_MODE, {rnd[17:11], p[1:0]});
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				e.is_cfg = 1'b0;
				e.idx    = '0;
				e.data   = '0;
				for (int c = 0; c < ppo_pkg::NUM_LANES; c++) begin
					rnd = $urandom;
					if (rnd[9:8] == 2'b00)
						e.pix[c] = {8{rnd[10]}};
					else if (rnd[9:8] == 2'b01)
						e.pix[c] = rnd[10] ? hi : lo;
					else
						e.pix[c] = rnd[7:0];
				end
				item_q.push_back(e);
			end
		end
	end

	// driver: register writes only go out with nothing in flight
	always @(posedge clk) begin
		entry_t e;
		logic   tx_free;
		logic   in_v_n;
		logic   cfg_v_n;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			tx_wait   = 0;
		end else begin
			tx_free = 1'b1;
			in_v_n  = in_valid;
			cfg_v_n = cfg_valid;
			if (in_valid) begin
				if (in_ready) begin
					exp_q.push_back(predict({chan2_in, chan1_in, chan0_in}));
					in_v_n  = 1'b0;
					tx_wait = $urandom_range(MAX_GAP, 0);
				end else begin
					tx_free = 1'b0;
				end
			end
			if (cfg_valid) begin
				if (cfg_ready) begin
					apply_cfg(cfg_index, cfg_data);
					cfg_v_n = 1'b0;
				end else begin
					tx_free = 1'b0;
				end
			end
			if (tx_free) begin
				if (tx_wait != 0) begin
					tx_wait = tx_wait - 1;
				end else if (item_q.size() != 0) begin
					if (!item_q[0].is_cfg) begin
						e        = item_q.pop_front();
						in_v_n   = 1'b1;
						chan0_in <= e.pix[0];
						chan1_in <= e.pix[1];
						chan2_in <= e.pix[2];
					end else if (exp_q.size() == 0) begin
						e         = item_q.pop_front();
						cfg_v_n   = 1'b1;
						cfg_index <= e.idx;
						cfg_data  <= e.data;
					end
				end
			end
			in_valid  <= in_v_n;
			cfg_valid <= cfg_v_n;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {chan2_out, chan1_out, chan0_out};
				if (exp_q.size() == 0) begin
					if (err_cnt < REPORT_MAX)
						$display("unexpected transfer at %0t: got %h %h %h",
							$time, got[0], got[1], got[2]);
					err_cnt = err_cnt + 1;
				end else begin
					want = exp_q.pop_front();
					if (got !== want) begin
						if (err_cnt < REPORT_MAX)
							$display("mismatch at %0t: expected %h %h %h, got %h %h %h",
								$time, want[0], want[1], want[2], got[0], got[1], got[2]);
						err_cnt = err_cnt + 1;
					end
				end
				rcv_cnt <= rcv_cnt + 1;
				rx_wait = $urandom_range(MAX_GAP, 0);
			end else if (rx_wait != 0) begin
				rx_wait = rx_wait - 1;
			end
			out_ready <= (rx_wait == 0) && !hold_on;
		end
	end

	// one long receiver hold-off while the sender keeps going
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_on   <= 1'b0;
			hold_done <= 1'b0;
			hold_cnt  <= 0;
		end else if (hold_on) begin
			if (hold_cnt == LONG_HOLD - 1) begin
				hold_on   <= 1'b0;
				hold_done <= 1'b1;
			end
			hold_cnt <= hold_cnt + 1;
		end else if (!hold_done && rcv_cnt >= HOLD_AFTER) begin
			hold_on <= 1'b1;
		end
	end

	initial begin : finish_blk
		wait (arst_n === 1'b1);
		wait (rcv_cnt == N_PIX);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && exp_q.size() == 0 && item_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : limit_blk
		#(LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
